// File: hw/rtl/temperature_display_packet_framer_assert.svh
// Assertion macros used by the checker of the temperature display framer.
`ifndef TEMPERATURE_DISPLAY_PACKET_FRAMER_ASSERT_SVH
`define TEMPERATURE_DISPLAY_PACKET_FRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDPF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TDPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

// File: hw/rtl/tdpf_pkg.sv
package tdpf_pkg;

    localparam int unsigned FRAME_LEN  = 13;
    localparam int unsigned DIGIT_POS  = 6;
    localparam int unsigned LAST_POS   = FRAME_LEN - 1;
    localparam int unsigned MAX_TENTHS = 999;
    localparam logic [7:0]  ERR_DIGIT  = 8'd238;

    // Six display digits: CPU tens, units, tenths, then the same for the GPU.
    typedef struct packed {
        logic [5:0][7:0] digits;
    } t_frame;

    typedef struct packed {
        logic [3:0] quo;
        logic [9:0] rem;
    } t_split;

    function automatic logic [7:0] frame_header(input logic [3:0] pos);
        logic [7:0] b;
        b = 8'h00;
        unique case (pos)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h55;
            4'd2:    b = 8'hAA;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h01;
            4'd5:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Hundreds digit of a value below 1000, found by comparison against constants.
    function automatic t_split split_hundreds(input logic [9:0] v);
        t_split s;
        s.quo = 4'd0;
        s.rem = v;
        for (int k = 1; k < 10; k++) begin
            if (v >= 10'(k * 100)) begin
                s.quo = 4'(k);
                s.rem = v - 10'(k * 100);
            end
        end
        return s;
    endfunction

    // Tens digit of a value below 100.
    function automatic t_split split_tens(input logic [6:0] v);
        t_split s;
        s.quo = 4'd0;
        s.rem = {3'd0, v};
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(k * 10)) begin
                s.quo = 4'(k);
                s.rem = {3'd0, v - 7'(k * 10)};
            end
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/temperature_display_packet_framer.sv
// Temperature display frame builder.
// Input channel: push a CPU/GPU temperature pair (signed tenths of a degree) while
// full is low. Result channel: while empty is low, o_frame_byte/o_last_byte show
// the oldest waiting beat of a 13-byte frame; pop takes it.
// Frame: header 00 55 AA 01 01 06, three digits per temperature, then a checksum
// (sum of the first 12 bytes modulo 256) marked by o_last_byte. A negative value
// gives three 238 digits; values of 999 tenths and up show as 9 9 9.
// An accepted pair is registered in the front, written to the queue and, when the
// output side is idle, loaded into the sequencer, whose first beat then shows.
// All beats leave the single byte-wide output sequencer. The front converts a
// pair in two stages and a two-entry queue holds finished digit sets, so up to
// three pairs are taken while a frame is still being popped.
// A stalled receiver holds the current beat steady; the queue then fills and
// full rises. Reset (synchronous) empties the pipeline, the queue and the output.
module temperature_display_packet_framer
    import tdpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [11:0] i_cpu_tenths,
    input  logic signed [11:0] i_gpu_tenths,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_frame_byte,
    output logic               o_last_byte
);

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    t_frame q_wdata;
    t_frame q_rdata;

    tdpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cpu_tenths (i_cpu_tenths),
        .i_gpu_tenths (i_gpu_tenths),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    tdpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    tdpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

// File: hw/rtl/tdpf_front.sv
module tdpf_front
    import tdpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [11:0] i_cpu_tenths,
    input  logic signed [11:0] i_gpu_tenths,
    input  logic               i_q_full,
    output logic               o_q_push,
    output t_frame             o_q_data
);

    logic       r_valid;
    logic       r_err  [2];
    logic [3:0] r_hund [2];
    logic [6:0] r_rem  [2];

    logic       n_err  [2];
    logic [3:0] n_hund [2];
    logic [6:0] n_rem  [2];
    logic       accept;

    assign o_q_push = r_valid && !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;

    // First half of the conversion: error flag, clamp and hundreds digit.
    always_comb begin
        logic [11:0] t;
        logic [9:0]  v;
        t_split      s;
        for (int i = 0; i < 2; i++) begin
            t = (i == 0) ? i_cpu_tenths : i_gpu_tenths;
            v = (t[10:0] > 11'(MAX_TENTHS)) ? 10'(MAX_TENTHS) : t[9:0];
            s = split_hundreds(v);
            n_err[i]  = t[11];
            n_hund[i] = s.quo;
            n_rem[i]  = s.rem[6:0];
        end
    end

    // Second half: tens and tenths digits, straight into the queue.
    always_comb begin
        t_split s;
        o_q_data = '0;
        for (int i = 0; i < 2; i++) begin
            s = split_tens(r_rem[i]);
            if (r_err[i]) begin
                o_q_data.digits[3 * i]     = ERR_DIGIT;
                o_q_data.digits[3 * i + 1] = ERR_DIGIT;
                o_q_data.digits[3 * i + 2] = ERR_DIGIT;
            end else begin
                o_q_data.digits[3 * i]     = {4'd0, r_hund[i]};
                o_q_data.digits[3 * i + 1] = {4'd0, s.quo};
                o_q_data.digits[3 * i + 2] = {4'd0, s.rem[3:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err  <= n_err;
            r_hund <= n_hund;
            r_rem  <= n_rem;
        end
    end

endmodule

// File: hw/rtl/tdpf_queue.sv
module tdpf_queue
    import tdpf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_frame o_data
);

    t_frame     r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/tdpf_back.sv
module tdpf_back
    import tdpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_frame     i_q_data,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);

    logic       r_active;
    logic [3:0] r_pos;
    logic [7:0] r_sum;
    t_frame     r_frame;

    logic       at_last;
    logic [2:0] digit_idx;

    assign at_last     = (r_pos == 4'(LAST_POS));
    assign digit_idx   = 3'(r_pos - 4'(DIGIT_POS));
    assign o_empty     = !r_active;
    assign o_last_byte = at_last;
    // A new frame is loaded when idle or as the checksum beat leaves.
    assign o_q_pop     = i_q_valid && (!r_active || (i_pop && at_last));

    always_comb begin
        priority if (r_pos < 4'(DIGIT_POS)) begin
            o_frame_byte = frame_header(r_pos);
        end else if (at_last) begin
            o_frame_byte = r_sum;
        end else begin
            o_frame_byte = r_frame.digits[digit_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= 4'd0;
            r_sum    <= 8'd0;
        end else if (o_q_pop) begin
            r_active <= 1'b1;
            r_pos    <= 4'd0;
            r_sum    <= 8'd0;
        end else if (r_active && i_pop) begin
            if (at_last) begin
                r_active <= 1'b0;
                r_pos    <= 4'd0;
                r_sum    <= 8'd0;
            end else begin
                r_pos <= r_pos + 4'd1;
                r_sum <= r_sum + o_frame_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_frame <= i_q_data;
        end
    end

endmodule

// File: hw/rtl/tdpf_checker.sv
`include "temperature_display_packet_framer_assert.svh"

module tdpf_checker
    import tdpf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_frame_byte,
    input logic       o_last_byte
);

    logic [3:0] r_beat;
    logic [7:0] r_sum;
    logic       beat_taken;

    assign beat_taken = pop && !empty;

    // Tracks the position and checksum of the frame seen on the ports.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= 4'd0;
            r_sum  <= 8'd0;
        end else if (beat_taken) begin
            if (r_beat == 4'(LAST_POS)) begin
                r_beat <= 4'd0;
                r_sum  <= 8'd0;
            end else begin
                r_beat <= r_beat + 4'd1;
                r_sum  <= r_sum + o_frame_byte;
            end
        end
    end

    `TDPF_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable({o_frame_byte, o_last_byte}))
    `TDPF_ASSERT_SAME(a_last_on_13th, !empty, o_last_byte == (r_beat == 4'(LAST_POS)))
    `TDPF_ASSERT_SAME(a_frame_starts_zero, !empty && r_beat == 4'd0, o_frame_byte == 8'h00)
    `TDPF_ASSERT_SAME(a_checksum, !empty && o_last_byte, o_frame_byte == r_sum)

endmodule

bind temperature_display_packet_framer tdpf_checker u_tdpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_frame_byte (o_frame_byte),
    .o_last_byte  (o_last_byte)
);

// File: verif/temperature_display_packet_framer_test.sv
`timescale 1ns / 1ps

module temperature_display_packet_framer_test;
    import tdpf_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PAIRS_PER_PHASE = 50;
    localparam logic [7:0] FRAME_HEADER [6] = '{8'h00, 8'h55, 8'hAA, 8'h01, 8'h01, 8'h06};

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [11:0] i_cpu_tenths = '0;
    logic signed [11:0] i_gpu_tenths = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [7:0]         o_frame_byte;
    logic               o_last_byte;

    t_frame_beat pending_beats[$];
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int pairs_sent = 0;
    int beats_checked = 0;
    int dash_temps = 0;
    int clamped_temps = 0;

    temperature_display_packet_framer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cpu_tenths (i_cpu_tenths),
        .i_gpu_tenths (i_gpu_tenths),
        .empty        (empty),
        .pop          (pop),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, pending_beats.size());
            $display("** temperature_display_packet_framer: FAILED **");
            $finish;
        end
    end

    // Tens, units and tenths digits shown for one temperature.
    function automatic logic [2:0][7:0] display_digits(input logic signed [11:0] tenths);
        int v;
        if (tenths < 0) begin
            dash_temps++;
            return {ERR_DIGIT, ERR_DIGIT, ERR_DIGIT};
        end
        v = int'(tenths);
        if (v > int'(MAX_TENTHS)) begin
            clamped_temps++;
            v = int'(MAX_TENTHS);
        end
        return {8'(v / 100), 8'((v / 10) % 10), 8'(v % 10)};
    endfunction

    function automatic void predict_frame(input logic signed [11:0] cpu,
                                          input logic signed [11:0] gpu);
        logic [2:0][7:0] cpu_digits;
        logic [2:0][7:0] gpu_digits;
        logic [7:0]      checksum;
        logic [7:0]      body [12];
        cpu_digits = display_digits(cpu);
        gpu_digits = display_digits(gpu);
        for (int k = 0; k < 6; k++) body[k] = FRAME_HEADER[k];
        for (int k = 0; k < 3; k++) begin
            body[6 + k] = cpu_digits[2 - k];
            body[9 + k] = gpu_digits[2 - k];
        end
        checksum = 8'h00;
        for (int k = 0; k < 12; k++) begin
            checksum = checksum + body[k];
            pending_beats.insert(pending_beats.size(),
                                 t_frame_beat'{value: body[k], last: 1'b0});
        end
        pending_beats.insert(pending_beats.size(), t_frame_beat'{value: checksum, last: 1'b1});
    endfunction

    // Flags are sampled before the edge takes effect, so a beat counts when pop
    // was high and empty low going into this edge.
    always @(posedge i_clk) begin
        t_frame_beat exp_beat;
        if (i_rst_n && pop && !empty) begin
            beats_checked++;
            if (pending_beats.size() == 0) begin
                error_count++;
                $error("unexpected beat: frame_byte %0d, last_byte %0b",
                       o_frame_byte, o_last_byte);
            end else begin
                exp_beat = pending_beats.pop_front();
                if (o_frame_byte !== exp_beat.value) begin
                    error_count++;
                    $error("frame_byte: expected %0d, got %0d", exp_beat.value, o_frame_byte);
                end
                if (o_last_byte !== exp_beat.last) begin
                    error_count++;
                    $error("last_byte: expected %0b, got %0b", exp_beat.last, o_last_byte);
                end
            end
        end
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send_pair(input logic [11:0] cpu, input logic [11:0] gpu);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            i_cpu_tenths <= 12'($urandom());
            i_gpu_tenths <= 12'($urandom());
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_cpu_tenths <= cpu;
        i_gpu_tenths <= gpu;
        do @(posedge i_clk); while (full);
        predict_frame(cpu, gpu);
        pairs_sent++;
    endtask

    function automatic logic [11:0] random_tenths();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return 12'($urandom_range(999));
        if (pick < 8) return 12'(1000 + $urandom_range(1047));
        if (pick < 9) return 12'(-int'($urandom_range(2048, 1)));
        return 12'($urandom());
    endfunction

    task automatic test_header_and_extremes();
        send_pair(12'd0, 12'd0);
        send_pair(12'h7FF, 12'h7FF);
        send_pair(12'h800, 12'h800);
        send_pair(12'h555, 12'h2AA);
        send_pair(12'h2AA, 12'h555);
        send_pair(12'd123, 12'd456);
        send_pair(12'd7, 12'd80);
    endtask

    task automatic test_error_digits();
        send_pair(-12'sd1, -12'sd1);
        send_pair(-12'sd1, 12'd0);
        send_pair(12'd0, -12'sd1);
        send_pair(12'h800, 12'd999);
        send_pair(-12'sd1000, 12'd1);
    endtask

    // Values near the top of the display range, where 100.0 and above must clamp.
    task automatic test_saturation();
        send_pair(12'd999, 12'd999);
        send_pair(12'd1000, 12'd1000);
        send_pair(12'd995, 12'd1001);
        send_pair(12'd998, 12'd999);
        send_pair(12'd1999, 12'd2047);
        send_pair(12'd100, 12'd99);
        send_pair(12'd10, 12'd9);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < RANDOM_PAIRS_PER_PHASE; n++)
            send_pair(random_tenths(), random_tenths());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_and_extremes();
        test_error_digits();
        test_saturation();
        test_random_traffic(0, 0);
        test_random_traffic(85, 0);
        test_random_traffic(0, 85);
        test_random_traffic(24, 24);

        push <= 1'b0;
        receiver_stall_pct = 0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d temperature pairs and checked %0d frame beats", pairs_sent,
                 beats_checked);
        $display("covered %0d sensor-error and %0d clamped readings under four flow mixes",
                 dash_temps, clamped_temps);
        if (error_count == 0)
            $display("** temperature_display_packet_framer: PASSED **");
        else
            $display("** temperature_display_packet_framer: FAILED **");
        $finish;
    end

endmodule
